/* rtl/rge_pkg.sv */
// ----------------------------------------------------------------------------
// rge_pkg
// Types and constants shared by the reciprocal gain equalizer modules.
// ----------------------------------------------------------------------------
package rge_pkg;

    localparam int NUM_LANES   = 8;
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 10;
    localparam int MAG_W       = 10;
    localparam int BPS_W       = 4;
    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_IDX_W = 8;

    localparam int unsigned GAIN_NUMERATOR = 512;

    localparam logic [BPS_W-1:0] BPS_16QAM = 4'd4;
    localparam logic [BPS_W-1:0] BPS_RESET = 4'd4;

    localparam logic [MAG_W-1:0] MAG_16QAM  = 10'd324;
    localparam logic [MAG_W-1:0] MAG_64QAM  = 10'd316;
    localparam logic [MAG_W-1:0] MAGB_64QAM = 10'd158;
    localparam logic [MAG_W-1:0] MAG_NONE   = 10'd0;

    typedef logic [NUM_LANES-1:0][SAMPLE_W-1:0] sample_vec_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_0;
        logic signed [SAMPLE_W-1:0] sample_1;
        logic signed [SAMPLE_W-1:0] sample_2;
        logic signed [SAMPLE_W-1:0] sample_3;
        logic signed [SAMPLE_W-1:0] sample_4;
        logic signed [SAMPLE_W-1:0] sample_5;
        logic signed [SAMPLE_W-1:0] sample_6;
        logic signed [SAMPLE_W-1:0] sample_7;
        logic signed [SAMPLE_W-1:0] channel_magnitude;
        logic                       last_in;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] scaled_0;
        logic signed [SAMPLE_W-1:0] scaled_1;
        logic signed [SAMPLE_W-1:0] scaled_2;
        logic signed [SAMPLE_W-1:0] scaled_3;
        logic signed [SAMPLE_W-1:0] scaled_4;
        logic signed [SAMPLE_W-1:0] scaled_5;
        logic signed [SAMPLE_W-1:0] scaled_6;
        logic signed [SAMPLE_W-1:0] scaled_7;
        logic [MAG_W-1:0]           decision_magnitude;
        logic [MAG_W-1:0]           second_magnitude;
        logic                       second_write;
        logic                       last_out;
    } out_item_t;

    typedef struct packed {
        logic advance;
        logic in_valid;
    } pipe_ctrl_t;

endpackage

/* rtl/reciprocal_gain_equalizer_unit.sv */
// ----------------------------------------------------------------------------
// reciprocal_gain_equalizer_unit
// Zero-forcing style equalizer for four complex subcarriers per request.
// ----------------------------------------------------------------------------
// Accepts one request per cycle while the result is not stalled: the first
// stage clamps the channel magnitude and reads the reciprocal gain from a
// 256-entry constant table, the second stage has eight multiplier lanes, one
// per sample, whose registers hold the result. The whole pipeline holds while
// the result is stalled. bits_per_symbol may only be written while no request
// is in flight.
module reciprocal_gain_equalizer_unit #(
    parameter int MAGNITUDE_LIMIT = 255
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [rge_pkg::BPS_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  rge_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output rge_pkg::out_item_t                out_data
);

    logic [rge_pkg::BPS_W-1:0] bps_reg, bps_next;
    logic                      valid_reg, valid_next;
    logic                      last_reg, last_next;

    rge_pkg::pipe_ctrl_t        ctrl;
    logic                       s1_valid;
    logic [rge_pkg::GAIN_W-1:0] s1_gain;
    rge_pkg::sample_vec_t       s1_samples;
    logic                       s1_last;
    rge_pkg::sample_vec_t       lane_scaled;

    assign ctrl.advance  = !(valid_reg && out_stall);
    assign ctrl.in_valid = in_valid;
    assign in_stall      = !ctrl.advance;

    rge_gain_stage #(
        .MAGNITUDE_LIMIT(MAGNITUDE_LIMIT)
    ) u_gain_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .in_data (in_data),
        .valid   (s1_valid),
        .gain    (s1_gain),
        .samples (s1_samples),
        .last    (s1_last)
    );

    for (genvar l = 0; l < rge_pkg::NUM_LANES; l++) begin : g_lane
        rge_lane u_lane (
            .clk     (clk),
            .advance (ctrl.advance),
            .sample  (s1_samples[l]),
            .gain    (s1_gain),
            .scaled  (lane_scaled[l])
        );
    end

    always_comb
    begin
        bps_next   = cfg_write ? cfg_data : bps_reg;
        valid_next = ctrl.advance ? s1_valid : valid_reg;
        last_next  = ctrl.advance ? s1_last : last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_reg   <= rge_pkg::BPS_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            bps_reg   <= bps_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
    end

    rge_merge u_merge (
        .scaled          (lane_scaled),
        .bits_per_symbol (bps_reg),
        .last            (last_reg),
        .out_data        (out_data)
    );

    assign out_valid = valid_reg;

endmodule

/* rtl/rge_gain_stage.sv */
// ----------------------------------------------------------------------------
// rge_gain_stage
// Clamps the channel magnitude, looks up the reciprocal gain and registers
// it together with the samples of the request.
// ----------------------------------------------------------------------------
module rge_gain_stage #(
    parameter int MAGNITUDE_LIMIT = 255
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rge_pkg::pipe_ctrl_t        ctrl,
    input  rge_pkg::in_item_t          in_data,
    output logic                       valid,
    output logic [rge_pkg::GAIN_W-1:0] gain,
    output rge_pkg::sample_vec_t       samples,
    output logic                       last
);

    localparam int AMP_W = (MAGNITUDE_LIMIT < 2) ? 1 : $clog2(MAGNITUDE_LIMIT + 1);
    localparam logic [AMP_W-1:0] AmpLimit = AMP_W'(MAGNITUDE_LIMIT);

    logic [rge_pkg::GAIN_W-1:0] gain_rom [rge_pkg::TABLE_DEPTH];

    for (genvar g = 0; g < rge_pkg::TABLE_DEPTH; g++) begin : g_rom
        localparam logic [rge_pkg::GAIN_W-1:0] GainValue =
            rge_pkg::GAIN_W'(rge_pkg::GAIN_NUMERATOR / (g + 1));
        assign gain_rom[g] = GainValue;
    end

    logic                       valid_reg,   valid_next;
    logic [rge_pkg::GAIN_W-1:0] gain_reg,    gain_next;
    rge_pkg::sample_vec_t       samples_reg, samples_next;
    logic                       last_reg,    last_next;

    logic signed [rge_pkg::SAMPLE_W-1:0] mag;
    logic [AMP_W-1:0]                    amp;
    logic [15:0]                         amp_wide;

    always_comb
    begin
        mag = in_data.channel_magnitude;
        if (mag < 0)
        begin
            amp = '0;
        end
        else if (32'(mag) > MAGNITUDE_LIMIT)
        begin
            amp = AmpLimit;
        end
        else
        begin
            amp = mag[AMP_W-1:0];
        end
        amp_wide = 16'(amp);
    end

    always_comb
    begin
        valid_next   = valid_reg;
        gain_next    = gain_reg;
        samples_next = samples_reg;
        last_next    = last_reg;
        if (ctrl.advance)
        begin
            valid_next = ctrl.in_valid;
            if (amp_wide < 16'(rge_pkg::TABLE_DEPTH))
            begin
                gain_next = gain_rom[amp_wide[rge_pkg::TABLE_IDX_W-1:0]];
            end
            else if (amp_wide < 16'(rge_pkg::GAIN_NUMERATOR))
            begin
                gain_next = rge_pkg::GAIN_W'(1);
            end
            else
            begin
                gain_next = '0;
            end
            samples_next = {in_data.sample_7, in_data.sample_6, in_data.sample_5,
                            in_data.sample_4, in_data.sample_3, in_data.sample_2,
                            in_data.sample_1, in_data.sample_0};
            last_next    = in_data.last_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gain_reg    <= gain_next;
        samples_reg <= samples_next;
        last_reg    <= last_next;
    end

    assign valid   = valid_reg;
    assign gain    = gain_reg;
    assign samples = samples_reg;
    assign last    = last_reg;

endmodule

/* rtl/rge_lane.sv */
// ----------------------------------------------------------------------------
// rge_lane
// One multiplier lane: scales one sample by the gain and keeps the low bits.
// ----------------------------------------------------------------------------
module rge_lane (
    input  logic                         clk,
    input  logic                         advance,
    input  logic [rge_pkg::SAMPLE_W-1:0] sample,
    input  logic [rge_pkg::GAIN_W-1:0]   gain,
    output logic [rge_pkg::SAMPLE_W-1:0] scaled
);

    localparam int PROD_W = rge_pkg::SAMPLE_W + rge_pkg::GAIN_W;

    logic [rge_pkg::SAMPLE_W-1:0] scaled_reg, scaled_next;
    logic [PROD_W-1:0]            product;

    always_comb
    begin
        product     = PROD_W'(sample) * PROD_W'(gain);
        scaled_next = advance ? product[rge_pkg::SAMPLE_W-1:0] : scaled_reg;
    end

    always_ff @(posedge clk)
    begin
        scaled_reg <= scaled_next;
    end

    assign scaled = scaled_reg;

endmodule

/* rtl/rge_merge.sv */
// ----------------------------------------------------------------------------
// rge_merge
// Gathers the lane results and the decision magnitudes into one result.
// ----------------------------------------------------------------------------
module rge_merge (
    input  rge_pkg::sample_vec_t       scaled,
    input  logic [rge_pkg::BPS_W-1:0]  bits_per_symbol,
    input  logic                       last,
    output rge_pkg::out_item_t         out_data
);

    always_comb
    begin
        out_data.scaled_0 = scaled[0];
        out_data.scaled_1 = scaled[1];
        out_data.scaled_2 = scaled[2];
        out_data.scaled_3 = scaled[3];
        out_data.scaled_4 = scaled[4];
        out_data.scaled_5 = scaled[5];
        out_data.scaled_6 = scaled[6];
        out_data.scaled_7 = scaled[7];
        out_data.last_out = last;
        if (bits_per_symbol == rge_pkg::BPS_16QAM)
        begin
            out_data.decision_magnitude = rge_pkg::MAG_16QAM;
            out_data.second_magnitude   = rge_pkg::MAG_NONE;
            out_data.second_write       = 1'b0;
        end
        else
        begin
            out_data.decision_magnitude = rge_pkg::MAG_64QAM;
            out_data.second_magnitude   = rge_pkg::MAGB_64QAM;
            out_data.second_write       = 1'b1;
        end
    end

endmodule

/* bench/rge_checker.sv */
// ----------------------------------------------------------------------------
// rge_checker
// Watches the request, result and configuration ports of the reciprocal gain
// equalizer. Every accepted request is equalized here: the magnitude is
// clamped, the reciprocal gain is looked up by division, the eight samples
// are scaled with 16-bit wrap, and the QAM magnitudes follow the mode. Each
// accepted result is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module rge_checker #(
    parameter int MAGNITUDE_LIMIT = 255
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [rge_pkg::BPS_W-1:0] cfg_data,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  rge_pkg::in_item_t         in_data,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  rge_pkg::out_item_t        out_data,
    output int                        mismatch_count,
    output int                        groups_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    import rge_pkg::*;

    logic [BPS_W-1:0] mode_bps;
    out_item_t        equalized_q[$];
    int               result_number;

    function automatic logic [SAMPLE_W-1:0] scale_lane(logic [SAMPLE_W-1:0] sample,
                                                       logic [31:0] gain);
        logic [31:0] product;
        product = {16'd0, sample} * gain;
        return product[SAMPLE_W-1:0];
    endfunction

    function automatic out_item_t equalize_group(in_item_t grp, logic [BPS_W-1:0] bps);
        out_item_t   res;
        int          amp;
        logic [31:0] gain;
        amp = grp.channel_magnitude;
        if (amp < 0)
            amp = 0;
        if (amp > MAGNITUDE_LIMIT)
            amp = MAGNITUDE_LIMIT;
        gain = GAIN_NUMERATOR / (amp + 1);
        res.scaled_0 = scale_lane(grp.sample_0, gain);
        res.scaled_1 = scale_lane(grp.sample_1, gain);
        res.scaled_2 = scale_lane(grp.sample_2, gain);
        res.scaled_3 = scale_lane(grp.sample_3, gain);
        res.scaled_4 = scale_lane(grp.sample_4, gain);
        res.scaled_5 = scale_lane(grp.sample_5, gain);
        res.scaled_6 = scale_lane(grp.sample_6, gain);
        res.scaled_7 = scale_lane(grp.sample_7, gain);
        if (bps == BPS_16QAM)
        begin
            res.decision_magnitude = MAG_16QAM;
            res.second_magnitude   = MAG_NONE;
            res.second_write       = 1'b0;
        end
        else
        begin
            res.decision_magnitude = MAG_64QAM;
            res.second_magnitude   = MAGB_64QAM;
            res.second_write       = 1'b1;
        end
        res.last_out = grp.last_in;
        return res;
    endfunction

    task automatic log_mismatch(string msg);
        $display("[%0t] rge_checker: result %0d: %s", $realtime, result_number, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [SAMPLE_W-1:0] got,
                               logic [SAMPLE_W-1:0] want);
        if (got !== want)
            log_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            mode_bps = BPS_RESET;
            equalized_q.delete();
            result_number = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (equalized_q.size() == 0)
                    log_mismatch("result with no request outstanding");
                else
                begin
                    want = equalized_q.pop_front();
                    check_field("scaled_0", out_data.scaled_0, want.scaled_0);
                    check_field("scaled_1", out_data.scaled_1, want.scaled_1);
                    check_field("scaled_2", out_data.scaled_2, want.scaled_2);
                    check_field("scaled_3", out_data.scaled_3, want.scaled_3);
                    check_field("scaled_4", out_data.scaled_4, want.scaled_4);
                    check_field("scaled_5", out_data.scaled_5, want.scaled_5);
                    check_field("scaled_6", out_data.scaled_6, want.scaled_6);
                    check_field("scaled_7", out_data.scaled_7, want.scaled_7);
                    check_field("decision_magnitude", 16'(out_data.decision_magnitude),
                                16'(want.decision_magnitude));
                    check_field("second_magnitude", 16'(out_data.second_magnitude),
                                16'(want.second_magnitude));
                    check_field("second_write", 16'(out_data.second_write),
                                16'(want.second_write));
                    check_field("last_out", 16'(out_data.last_out), 16'(want.last_out));
                end
                result_number++;
            end
            if (in_valid && !in_stall)
                equalized_q.push_back(equalize_group(in_data, mode_bps));
            if (cfg_write)
                mode_bps = cfg_data;
        end
        groups_in_flight = equalized_q.size();
    end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives the reciprocal gain equalizer with directed corner requests and
// random requests under several modulation settings, with random idling on
// both channels and one long result hold-off, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rge_pkg::*;

    localparam int               MAG_LIMIT       = 255;
    localparam int               NUM_PHASES      = 8;
    localparam int               ITEMS_PER_PHASE = 150;
    localparam int               NUM_DIRECTED    = 12;
    localparam int               HOLD_CYCLES     = 80;
    localparam int               CYCLE_LIMIT     = 200000;
    localparam logic [BPS_W-1:0] BPS_MIN         = 4'd0;
    localparam logic [BPS_W-1:0] BPS_MAX         = 4'd15;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_write = 1'b0;
    logic [BPS_W-1:0] cfg_data  = BPS_RESET;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    in_item_t         in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_item_t        out_data;

    int mismatch_count;
    int groups_in_flight;
    int cycle_count   = 0;
    bit idle_enable   = 1'b1;
    bit hold_off_req  = 1'b0;

    reciprocal_gain_equalizer_unit #(
        .MAGNITUDE_LIMIT(MAG_LIMIT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    rge_checker #(
        .MAGNITUDE_LIMIT(MAG_LIMIT)
    ) u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_data          (in_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_data         (out_data),
        .mismatch_count   (mismatch_count),
        .groups_in_flight (groups_in_flight)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [SAMPLE_W-1:0] corner_word(int i);
        case (i % 8)
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'hAAAA;
            5:       return 16'h5555;
            6:       return 16'h0001;
            default: return 16'h00FF;
        endcase
    endfunction

    function automatic in_item_t directed_group(int k);
        in_item_t grp;
        grp.sample_0 = corner_word(k);
        grp.sample_1 = corner_word(k + 1);
        grp.sample_2 = corner_word(k + 2);
        grp.sample_3 = corner_word(k + 3);
        grp.sample_4 = corner_word(k + 4);
        grp.sample_5 = corner_word(k + 5);
        grp.sample_6 = corner_word(k + 6);
        grp.sample_7 = corner_word(k + 7);
        case (k)
            0:       grp.channel_magnitude = 16'h8000;
            1:       grp.channel_magnitude = 16'hFFFF;
            2:       grp.channel_magnitude = 16'd0;
            3:       grp.channel_magnitude = 16'd1;
            4:       grp.channel_magnitude = 16'd2;
            5:       grp.channel_magnitude = 16'd127;
            6:       grp.channel_magnitude = 16'd254;
            7:       grp.channel_magnitude = 16'd255;
            8:       grp.channel_magnitude = 16'd256;
            9:       grp.channel_magnitude = 16'd511;
            10:      grp.channel_magnitude = 16'h7FFF;
            default: grp.channel_magnitude = 16'd3;
        endcase
        grp.last_in = (k % 2) == 1;
        return grp;
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        if ($urandom_range(0, 7) == 0)
            return corner_word($urandom_range(0, 7));
        return 16'($urandom());
    endfunction

    function automatic in_item_t random_group();
        in_item_t grp;
        grp.sample_0 = random_sample();
        grp.sample_1 = random_sample();
        grp.sample_2 = random_sample();
        grp.sample_3 = random_sample();
        grp.sample_4 = random_sample();
        grp.sample_5 = random_sample();
        grp.sample_6 = random_sample();
        grp.sample_7 = random_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: grp.channel_magnitude = 16'($urandom_range(0, 255));
            6:                grp.channel_magnitude = 16'($urandom_range(256, 32767));
            7:                grp.channel_magnitude = 16'(-$urandom_range(1, 32768));
            8:                grp.channel_magnitude = 16'($urandom());
            default:          grp.channel_magnitude = 16'($urandom_range(0, 3));
        endcase
        grp.last_in = $urandom_range(0, 3) == 0;
        return grp;
    endfunction

    task automatic send_group(input in_item_t grp);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= grp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_directed();
        int k;
        for (k = 0; k < NUM_DIRECTED; k++)
            send_group(directed_group(k));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (groups_in_flight != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(input logic [BPS_W-1:0] mode);
        cfg_write <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin : result_side
        int burst;
        bit hold_served;
        hold_served = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_served)
            begin
                hold_served = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 7);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : request_side
        int               phase;
        logic [BPS_W-1:0] mode;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_directed();
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_results();
            case (phase)
                0:       mode = BPS_MIN;
                1:       mode = BPS_MAX;
                2:       mode = BPS_16QAM;
                default: mode = ($urandom_range(0, 2) == 0) ? BPS_16QAM
                                                             : 4'($urandom_range(0, 15));
            endcase
            write_mode(mode);
            if (phase == 0)
                send_directed();
            if (phase == 2)
                hold_off_req = 1'b1;
            if (phase == NUM_PHASES - 1)
                idle_enable = 1'b0;
            repeat (ITEMS_PER_PHASE)
                send_group(random_group());
        end
        drain_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
